// ----- design/wpm_pkg.sv -----
package wpm_pkg;

    // Pattern capacity in characters.
    localparam int PAT_LEN = 32;
    // Length counter width: must hold 0..PAT_LEN.
    localparam int LEN_W   = $clog2(PAT_LEN + 1);

    localparam logic [7:0] CH_BANG = 8'h21;  // '!'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'
    localparam logic [7:0] CH_ANY  = 8'h3F;  // '?'

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } opcode_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic restart;  // reload the active bit with its home value
        logic step;     // advance on a name character
        logic wr_en;    // store the incoming pattern character
        logic valid;    // cell lies inside the stored pattern
        logic at_end;   // cell position equals the pattern length
    } cell_ctrl_t;

endpackage

// ----- design/wildcard_pattern_matcher.sv -----
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_opcode[1:0], s_char_value[7:0]
// m_        out        m_valid/m_ready    m_matched, m_pattern_overflow
//
// One request per cycle while s_ready is high, every opcode; an end-of-name
// result appears in the output register in the cycle after its request is taken.
// The cycle is set by the star closure, which ripples through the cell row
// like a carry chain of PAT_LEN cells.
// Reset (aresetn low, synchronous) empties the pattern, clears the invert and
// overflow flags and restarts the active set; there is no clearing pass.
// s_ready drops only while a result waits in the output register and m_ready
// is low.
module wildcard_pattern_matcher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_char_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_matched,
    output logic       m_pattern_overflow
);

    localparam int N = wpm_pkg::PAT_LEN;
    localparam int W = wpm_pkg::LEN_W;

    logic [W-1:0]      len_reg,  len_next;
    logic              inv_reg,  inv_next;
    logic              ovf_reg,  ovf_next;
    logic              tail_reg, tail_next;   // active bit past the last cell
    logic              m_valid_reg, m_valid_next;
    logic              matched_reg;
    logic              ovf_out_reg;

    logic              accept;
    wpm_pkg::opcode_t  op;
    logic              is_bang;
    logic              do_write;
    logic              restart;
    logic              step;
    logic              tail_cur;
    logic              hit;

    logic [N-1:0]      clo_w;
    logic [N-1:0]      fwd_w;
    logic [N-1:0]      hit_w;

    // Output register frees itself when taken, so a new request can enter
    // in the same cycle.
    assign s_ready = ~m_valid_reg | m_ready;
    assign accept  = s_valid & s_ready;
    assign op      = wpm_pkg::opcode_t'(s_opcode);

    // A leading bang on an empty, uninverted pattern is not stored.
    assign is_bang  = (len_reg == '0) & ~inv_reg & ~ovf_reg
                    & (s_char_value == wpm_pkg::CH_BANG);
    assign do_write = accept & (op == wpm_pkg::OP_APPEND) & ~is_bang
                    & (len_reg < W'(N));
    assign restart  = accept & (op != wpm_pkg::OP_NAME);
    assign step     = accept & (op == wpm_pkg::OP_NAME);

    // ---- cell row: one cell per pattern position -------------------------
    for (genvar gi = 0; gi < N; gi++) begin : g_cell
        wpm_pkg::cell_ctrl_t ctrl;
        logic                clo_in;
        logic                fwd_in;

        assign ctrl.restart = restart;
        assign ctrl.step    = step;
        assign ctrl.wr_en   = do_write & (len_reg == W'(gi));
        assign ctrl.valid   = (W'(gi) < len_reg);
        assign ctrl.at_end  = (len_reg == W'(gi));

        if (gi == 0) begin : g_head
            assign clo_in = 1'b0;
            assign fwd_in = 1'b0;
        end else begin : g_link
            assign clo_in = clo_w[gi-1];
            assign fwd_in = fwd_w[gi-1];
        end

        wpm_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .home    (gi == 0),
            .char_in (s_char_value),
            .clo_in  (clo_in),
            .fwd_in  (fwd_in),
            .clo_out (clo_w[gi]),
            .fwd_out (fwd_w[gi]),
            .hit_out (hit_w[gi])
        );
    end

    // Position N: reachable only when the pattern is full.
    assign tail_cur = tail_reg | clo_w[N-1];
    assign hit      = (|hit_w) | (tail_cur & (len_reg == W'(N)));

    always_comb begin
        len_next     = len_reg;
        inv_next     = inv_reg;
        ovf_next     = ovf_reg;
        tail_next    = tail_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        if (accept) begin
            unique case (op)
                wpm_pkg::OP_CLEAR: begin
                    len_next  = '0;
                    inv_next  = 1'b0;
                    ovf_next  = 1'b0;
                    tail_next = 1'b0;
                end
                wpm_pkg::OP_APPEND: begin
                    tail_next = 1'b0;
                    if (is_bang) begin
                        inv_next = 1'b1;
                    end else if (do_write) begin
                        len_next = len_reg + W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                wpm_pkg::OP_NAME: begin
                    tail_next = fwd_w[N-1];
                end
                wpm_pkg::OP_END: begin
                    tail_next    = 1'b0;
                    m_valid_next = 1'b1;
                end
                default: begin
                    tail_next = tail_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            inv_reg     <= 1'b0;
            ovf_reg     <= 1'b0;
            tail_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            inv_reg     <= inv_next;
            ovf_reg     <= ovf_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Verdict: invert, then force low on overflow.
    always_ff @(posedge aclk) begin
        if (accept && op == wpm_pkg::OP_END) begin
            matched_reg <= (hit ^ inv_reg) & ~ovf_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = matched_reg;
    assign m_pattern_overflow = ovf_out_reg;

    // ---- checks ----------------------------------------------------------
    a_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= W'(N))
        else $error("pattern length past capacity");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (len_reg == W'(N)))
        else $error("overflow flagged with room left");

    a_end_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op == wpm_pkg::OP_END) |=> m_valid_reg)
        else $error("end of name gave no result");

    a_ovf_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && ovf_out_reg) |-> !matched_reg)
        else $error("match reported on overflowed pattern");

endmodule

// ----- design/wpm_cell.sv -----
module wpm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  wpm_pkg::cell_ctrl_t ctrl,
    input  logic                home,
    input  logic [7:0]          char_in,
    input  logic                clo_in,
    input  logic                fwd_in,
    output logic                clo_out,
    output logic                fwd_out,
    output logic                hit_out
);

    logic [7:0] char_reg;
    logic       active_reg;
    logic       active_next;
    logic       cur;
    logic       is_star;
    logic       hits_char;

    // Position is live if stored active or reached over stars to the left.
    assign cur       = active_reg | clo_in;
    assign is_star   = (char_reg == wpm_pkg::CH_STAR);
    assign hits_char = (char_reg == wpm_pkg::CH_ANY) | (char_reg == char_in);

    assign clo_out = cur & ctrl.valid & is_star;
    assign fwd_out = cur & ctrl.valid & ~is_star & hits_char;
    assign hit_out = cur & ctrl.at_end;

    always_comb begin
        active_next = active_reg;
        if (ctrl.restart) begin
            active_next = home;
        end else if (ctrl.step) begin
            // star keeps itself alive; a match hands over from the left
            active_next = (cur & ctrl.valid & is_star) | fwd_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= home;
        end else begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            char_reg <= char_in;
        end
    end

endmodule
